// ===== rtl/mlptw_pkg.sv =====
`timescale 1ns / 1ps

package mlptw_pkg;

  // Parameter defaults.
  localparam int ADDRESS_BITS_DEF   = 32;
  localparam int MAX_LEVELS_DEF     = 4;
  localparam int MAX_LEVEL_BITS_DEF = 8;
  localparam int NODE_COUNT_DEF     = 256;

  // Fixed field widths.
  localparam int ADDR_W     = 32;
  localparam int FRAME_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int BITS_W     = 4;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Number of per-level bit-count registers, and the width of a level number.
  localparam int CFG_LEVELS = 4;
  localparam int LEVEL_W    = 2;

  // Operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_POOL    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_CFG = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_ZERO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_THREE  = 3'd4;

  // Register reset values.
  localparam logic [COUNT_W-1:0] LEVEL_COUNT_RST = 3'd1;
  localparam logic [BITS_W-1:0]  LEVEL_BITS_RST  = 4'd8;

endpackage

// ===== rtl/mlptw_index.sv =====
`timescale 1ns / 1ps

// Shared index extractor: shifts the address right so that the current level's
// field lands at the bottom, then masks it to that level's bit count.
module mlptw_index #(
  parameter int ADDRESS_BITS   = mlptw_pkg::ADDRESS_BITS_DEF,
  parameter int MAX_LEVEL_BITS = mlptw_pkg::MAX_LEVEL_BITS_DEF,
  parameter int SW             = $clog2(ADDRESS_BITS + 1)
) (
  input  logic [ADDRESS_BITS-1:0]       addr,
  input  logic [SW-1:0]                 used,
  input  logic [mlptw_pkg::BITS_W-1:0]  bits,
  output logic [MAX_LEVEL_BITS-1:0]     idx
);

  localparam int XW = (ADDRESS_BITS > MAX_LEVEL_BITS) ? ADDRESS_BITS : MAX_LEVEL_BITS;

  logic [SW-1:0]             shift;
  logic [XW-1:0]             shifted;
  logic [MAX_LEVEL_BITS:0]   one_hot;
  logic [MAX_LEVEL_BITS-1:0] mask;

  always_comb begin
    shift   = SW'(ADDRESS_BITS) - used;
    shifted = XW'(addr) >> shift;
    one_hot = (MAX_LEVEL_BITS + 1)'(1) << bits;
    mask    = MAX_LEVEL_BITS'(one_hot - (MAX_LEVEL_BITS + 1)'(1));
    idx     = shifted[MAX_LEVEL_BITS-1:0] & mask;
  end

endmodule

// ===== rtl/multilevel_page_table_walker_top.sv =====
`timescale 1ns / 1ps

// Multi-level radix page table with lookup and insert.
// Input requests arrive on in_* (tuser bit 0: 0 lookup, 1 insert; tdata holds the
// logical address in the low 32 bits and the frame to assign above it). One result
// request leaves on out_* for every input: tdata is the leaf frame (0 on a miss),
// tuser carries the mapped flag and a status code (ok, pool exhausted, bad config).
// The level split is set over cfg_*: index 0 is the level count, indexes 1 to 4 the
// bit counts of levels zero to three. Write configuration only while idle.
// Each level passes through a look state, which forms the index in the shared
// shift-and-mask unit and reads the entry store, and a check state, which checks
// the entry and perhaps writes it back. Requests are accepted only while idle, and
// the next item is accepted the cycle after the result is loaded, at the earliest,
// so one item is walked at a time. A bad configuration skips the walk and goes straight
// from acceptance to the emit state. The one entry read per level bounds the rate.
// After reset the block sweeps all NODE_COUNT * 2**MAX_LEVEL_BITS entries of the store
// (65536 by default) to zero, one entry per cycle, and holds in_tready low meanwhile;
// configuration writes are taken throughout. A stalled result stays in the
// output register, and a finished walk waits for that register to free up.
module multilevel_page_table_walker_top #(
  parameter int ADDRESS_BITS   = mlptw_pkg::ADDRESS_BITS_DEF,
  parameter int MAX_LEVELS     = mlptw_pkg::MAX_LEVELS_DEF,
  parameter int MAX_LEVEL_BITS = mlptw_pkg::MAX_LEVEL_BITS_DEF,
  parameter int NODE_COUNT     = mlptw_pkg::NODE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] logical_address, [63:32] frame_number
  input  logic [2*mlptw_pkg::ADDR_W-1:0]     in_tdata,
  // [0] operation
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] frame_out
  output logic [mlptw_pkg::FRAME_W-1:0]      out_tdata,
  // [0] mapped, [2:1] status
  output logic [mlptw_pkg::STATUS_W:0]       out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mlptw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlptw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int FW = mlptw_pkg::FRAME_W;
  localparam int BW = mlptw_pkg::BITS_W;
  localparam int CW = mlptw_pkg::COUNT_W;
  localparam int LW = mlptw_pkg::LEVEL_W;
  localparam int STW = mlptw_pkg::STATUS_W;
  localparam int NW = $clog2(NODE_COUNT);
  localparam int FREE_W = $clog2(NODE_COUNT + 1);
  localparam int AW = NW + MAX_LEVEL_BITS;
  localparam int DEPTH = NODE_COUNT * (2 ** MAX_LEVEL_BITS);
  localparam int SW = $clog2(ADDRESS_BITS + 1);
  localparam int SUM_W = 7;

  // Entry layout: present, child node, valid, assigned, frame.
  localparam int E_FRAME = 0;
  localparam int E_ASSIGNED = FW;
  localparam int E_VALID = FW + 1;
  localparam int E_CHILD = FW + 2;
  localparam int E_PRESENT = FW + 2 + NW;
  localparam int EW = FW + 3 + NW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [FREE_W-1:0]   nfree_r, nfree_nxt;
  logic [CW-1:0]       lcount_r;
  logic [BW-1:0]       lbits_r [mlptw_pkg::CFG_LEVELS];

  logic                op_r, op_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [FW-1:0]       frame_r, frame_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic [NW-1:0]       node_r, node_nxt;
  logic [SW-1:0]       used_r, used_nxt;
  logic [AW-1:0]       pos_r;
  logic                res_map_r, res_map_nxt;
  logic [FW-1:0]       res_frame_r, res_frame_nxt;
  logic [STW-1:0]      res_sts_r, res_sts_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [FW-1:0]       out_frame_r;
  logic                out_map_r;
  logic [STW-1:0]      out_sts_r;
  logic                out_load;

  logic [EW-1:0]       mem [DEPTH];
  logic [EW-1:0]       rdata_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [EW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;

  logic [BW-1:0]             bits_cur;
  logic [SW-1:0]             used_cur;
  logic [MAX_LEVEL_BITS-1:0] idx;
  logic                      cfg_ok;
  logic                      last_lvl;
  logic                      in_acc;
  logic [FW-1:0]             new_frame;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcount_r <= mlptw_pkg::LEVEL_COUNT_RST;
      for (int i = 0; i < mlptw_pkg::CFG_LEVELS; i++) begin
        lbits_r[i] <= mlptw_pkg::LEVEL_BITS_RST;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        mlptw_pkg::REG_LEVEL_COUNT: lcount_r   <= cfg_data[CW-1:0];
        mlptw_pkg::REG_BITS_ZERO:   lbits_r[0] <= cfg_data;
        mlptw_pkg::REG_BITS_ONE:    lbits_r[1] <= cfg_data;
        mlptw_pkg::REG_BITS_TWO:    lbits_r[2] <= cfg_data;
        mlptw_pkg::REG_BITS_THREE:  lbits_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The configuration is usable when the level count is nonzero and at most MAX_LEVELS,
  // each level in use has a legal width, and one or more offset bits lie below the fields.
  always_comb begin
    logic [SUM_W-1:0] sum;
    cfg_ok = (lcount_r != '0) &&
             ({1'b0, lcount_r} <= 4'(MAX_LEVELS)) &&
             ({1'b0, lcount_r} <= 4'(mlptw_pkg::CFG_LEVELS));
    sum = '0;
    for (int i = 0; i < mlptw_pkg::CFG_LEVELS; i++) begin
      if (lcount_r > CW'(i)) begin
        if (lbits_r[i] == '0 || {1'b0, lbits_r[i]} > 5'(MAX_LEVEL_BITS)) begin
          cfg_ok = 1'b0;
        end
        sum = sum + SUM_W'(lbits_r[i]);
        if (sum + SUM_W'(1) > SUM_W'(ADDRESS_BITS)) begin
          cfg_ok = 1'b0;
        end
      end
    end
  end

  assign bits_cur = lbits_r[lvl_r];
  assign used_cur = used_r + SW'(bits_cur);
  assign last_lvl = (CW'(lvl_r) + CW'(1)) == lcount_r;

  mlptw_index #(
    .ADDRESS_BITS  (ADDRESS_BITS),
    .MAX_LEVEL_BITS(MAX_LEVEL_BITS),
    .SW            (SW)
  ) u_index (
    .addr(addr_r),
    .used(used_cur),
    .bits(bits_cur),
    .idx (idx)
  );

  assign mem_raddr = {node_r, idx};
  assign new_frame = rdata_r[E_ASSIGNED] ? rdata_r[E_FRAME +: FW] : frame_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    nfree_nxt     = nfree_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    frame_nxt     = frame_r;
    lvl_nxt       = lvl_r;
    node_nxt      = node_r;
    used_nxt      = used_r;
    res_map_nxt   = res_map_r;
    res_frame_nxt = res_frame_r;
    res_sts_nxt   = res_sts_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = rdata_r;
    out_load      = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tuser[0];
          addr_nxt  = in_tdata[ADDRESS_BITS-1:0];
          frame_nxt = in_tdata[mlptw_pkg::ADDR_W +: FW];
          lvl_nxt   = '0;
          node_nxt  = '0;
          used_nxt  = '0;
          if (cfg_ok) begin
            state_nxt = S_LOOK;
          end else begin
            res_map_nxt   = 1'b0;
            res_frame_nxt = '0;
            res_sts_nxt   = mlptw_pkg::STS_BAD_CFG;
            state_nxt     = S_EMIT;
          end
        end
      end
      S_LOOK: begin
        used_nxt  = used_cur;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        res_map_nxt   = 1'b0;
        res_frame_nxt = '0;
        res_sts_nxt   = mlptw_pkg::STS_OK;
        if (!last_lvl) begin
          if (rdata_r[E_PRESENT]) begin
            node_nxt  = rdata_r[E_CHILD +: NW];
            lvl_nxt   = lvl_r + LW'(1);
            state_nxt = S_LOOK;
          end else if (op_r == mlptw_pkg::OP_LOOKUP) begin
            state_nxt = S_EMIT;
          end else if (nfree_r >= FREE_W'(NODE_COUNT)) begin
            res_sts_nxt = mlptw_pkg::STS_POOL;
            state_nxt   = S_EMIT;
          end else begin
            // Allocate the next pool node as the missing child.
            mem_we                   = 1'b1;
            mem_wdata[E_PRESENT]     = 1'b1;
            mem_wdata[E_CHILD +: NW] = nfree_r[NW-1:0];
            node_nxt                 = nfree_r[NW-1:0];
            nfree_nxt                = nfree_r + FREE_W'(1);
            lvl_nxt                  = lvl_r + LW'(1);
            state_nxt                = S_LOOK;
          end
        end else if (op_r == mlptw_pkg::OP_LOOKUP) begin
          res_map_nxt   = rdata_r[E_VALID];
          res_frame_nxt = rdata_r[E_VALID] ? rdata_r[E_FRAME +: FW] : '0;
          state_nxt     = S_EMIT;
        end else begin
          // The frame is stored only on the first assignment to this leaf.
          mem_we                   = 1'b1;
          mem_wdata[E_VALID]       = 1'b1;
          mem_wdata[E_ASSIGNED]    = 1'b1;
          mem_wdata[E_FRAME +: FW] = new_frame;
          res_map_nxt              = 1'b1;
          res_frame_nxt            = new_frame;
          state_nxt                = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nfree_r     <= FREE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nfree_r     <= nfree_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    addr_r      <= addr_nxt;
    frame_r     <= frame_nxt;
    lvl_r       <= lvl_nxt;
    node_r      <= node_nxt;
    used_r      <= used_nxt;
    res_map_r   <= res_map_nxt;
    res_frame_r <= res_frame_nxt;
    res_sts_r   <= res_sts_nxt;
    if (state_r == S_LOOK) begin
      pos_r <= mem_raddr;
    end
    if (out_load) begin
      out_map_r   <= res_map_r;
      out_frame_r <= res_frame_r;
      out_sts_r   <= res_sts_r;
    end
  end

  // Entry store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_frame_r;
  assign out_tuser  = {out_sts_r, out_map_r};

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfree_r <= FREE_W'(NODE_COUNT))
    else $error("node pool pointer beyond pool size");

  a_pool_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> nfree_r >= $past(nfree_r))
    else $error("node pool pointer moved backward");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_LOOK || state_r == S_EMIT))
    else $error("accepted request did not start a walk");

  a_fail_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sts_r != mlptw_pkg::STS_OK |-> !out_map_r && out_frame_r == '0)
    else $error("failed request reported as mapped");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_CHECK))
    else $error("entry store written outside clear or check");

endmodule

// ===== tb/page_walk_checker.sv =====
`timescale 1ns / 1ps

module page_walk_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  // [31:0] logical_address, [63:32] frame_number
  input  logic [2*mlptw_pkg::ADDR_W-1:0]     in_tdata,
  // [0] operation
  input  logic [0:0]                         in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] frame_out
  input  logic [mlptw_pkg::FRAME_W-1:0]      out_tdata,
  // [0] mapped, [2:1] status
  input  logic [mlptw_pkg::STATUS_W:0]       out_tuser,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [mlptw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlptw_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                 pending_walks,
  output int                                 fail_count
);
  import mlptw_pkg::*;

  localparam int NODE_ENTRIES  = 1 << MAX_LEVEL_BITS_DEF;
  localparam int STORE_ENTRIES = NODE_COUNT_DEF * NODE_ENTRIES;
  localparam int REPORT_LIMIT  = 50;

  typedef struct packed {
    logic                mapped;
    logic [FRAME_W-1:0]  frame;
    logic [STATUS_W-1:0] status;
  } walk_result_t;

  // Interior and leaf fields of an entry live side by side and never alias.
  bit               child_present [STORE_ENTRIES];
  int               child_node    [STORE_ENTRIES];
  bit               leaf_valid    [STORE_ENTRIES];
  bit               leaf_assigned [STORE_ENTRIES];
  bit [FRAME_W-1:0] leaf_frame    [STORE_ENTRIES];
  int               next_free_node;

  logic [COUNT_W-1:0] level_count;
  logic [BITS_W-1:0]  level_bits [CFG_LEVELS];

  walk_result_t expected_walks [$];
  walk_result_t seen;
  walk_result_t want;

  initial begin
    pending_walks = 0;
    fail_count    = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < REPORT_LIMIT) begin
      $display("ERROR %0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic walk_result_t walk_table(input logic op, input logic [ADDR_W-1:0] addr,
                                              input logic [FRAME_W-1:0] frame);
    walk_result_t res;
    int levels;
    int used;
    int lvl;
    int node;
    int pos;
    int shift [CFG_LEVELS];
    res = '0;
    res.status = STS_OK;
    levels = level_count;
    if (levels < 1 || levels > MAX_LEVELS_DEF) begin
      res.status = STS_BAD_CFG;
      return res;
    end
    used = 0;
    for (lvl = 0; lvl < levels; lvl++) begin
      if (level_bits[lvl] < 1 || level_bits[lvl] > MAX_LEVEL_BITS_DEF) begin
        res.status = STS_BAD_CFG;
        return res;
      end
      used += level_bits[lvl];
      // At least one offset bit has to remain below the indexed bits.
      if (used + 1 > ADDRESS_BITS_DEF) begin
        res.status = STS_BAD_CFG;
        return res;
      end
      shift[lvl] = ADDRESS_BITS_DEF - used;
    end
    node = 0;
    for (lvl = 0; lvl < levels; lvl++) begin
      pos = node * NODE_ENTRIES
            + int'((addr >> shift[lvl]) & ((32'd1 << level_bits[lvl]) - 32'd1));
      if (lvl + 1 < levels) begin
        if (!child_present[pos]) begin
          if (op == OP_LOOKUP) begin
            return res;
          end
          if (next_free_node >= NODE_COUNT_DEF) begin
            res.status = STS_POOL;
            return res;
          end
          child_present[pos] = 1'b1;
          child_node[pos]    = next_free_node;
          next_free_node++;
        end
        node = child_node[pos];
      end else begin
        if (op == OP_LOOKUP) begin
          if (leaf_valid[pos]) begin
            res.mapped = 1'b1;
            res.frame  = leaf_frame[pos];
          end
          return res;
        end
        // The frame sticks from the first insert on; later inserts only read it back.
        if (!leaf_assigned[pos]) begin
          leaf_frame[pos]    = frame;
          leaf_assigned[pos] = 1'b1;
        end
        leaf_valid[pos] = 1'b1;
        res.mapped = 1'b1;
        res.frame  = leaf_frame[pos];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      level_count    = LEVEL_COUNT_RST;
      level_bits     = '{default: LEVEL_BITS_RST};
      next_free_node = 1;
      expected_walks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEVEL_COUNT: level_count   = cfg_data[COUNT_W-1:0];
          REG_BITS_ZERO:   level_bits[0] = cfg_data;
          REG_BITS_ONE:    level_bits[1] = cfg_data;
          REG_BITS_TWO:    level_bits[2] = cfg_data;
          REG_BITS_THREE:  level_bits[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_walks.push_back(walk_table(in_tuser[0], in_tdata[ADDR_W-1:0],
                                            in_tdata[2*ADDR_W-1:ADDR_W]));
      end
      if (out_tvalid && out_tready) begin
        seen.mapped = out_tuser[0];
        seen.frame  = out_tdata;
        seen.status = out_tuser[STATUS_W:1];
        if (expected_walks.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: frame %0h flags %0b",
                                    out_tdata, out_tuser));
        end else begin
          want = expected_walks.pop_front();
          if (seen.mapped !== want.mapped) begin
            report_mismatch($sformatf("mapped %0b, expected %0b", seen.mapped, want.mapped));
          end
          if (seen.frame !== want.frame) begin
            report_mismatch($sformatf("frame_out %0h, expected %0h", seen.frame, want.frame));
          end
          if (seen.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", seen.status, want.status));
          end
        end
      end
    end
    pending_walks = expected_walks.size();
  end

endmodule

// ===== tb/multilevel_page_table_walker_top_tb.sv =====
`timescale 1ns / 1ps

module multilevel_page_table_walker_top_tb;
  import mlptw_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HISTORY_DEPTH = 64;
  localparam int DRAIN_CYCLES  = 40;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [2*ADDR_W-1:0]   in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [FRAME_W-1:0]    out_tdata;
  logic [STATUS_W:0]     out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int pending_walks;
  int fail_count;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  logic [ADDR_W-1:0] recent_addrs [$];

  multilevel_page_table_walker_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  page_walk_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_walks (pending_walks),
    .fail_count    (fail_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct    <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 53;
        stall_pct    <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct    <= 53;
      end
      default: begin
        send_idle_pct = 18;
        stall_pct    <= 18;
      end
    endcase
  endtask

  // Starts and ends at a falling edge; in_tvalid stays high after the request so that
  // back-to-back requests never lower and raise it in the same step.
  task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [FRAME_W-1:0] frame);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {frame, addr};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic program_levels(input logic [CFG_DATA_W-1:0] count_code, b0, b1, b2, b3);
    logic [CFG_IDX_W-1:0]  reg_index [5];
    logic [CFG_DATA_W-1:0] reg_value [5];
    int r;
    in_tvalid <= 1'b0;
    while (pending_walks != 0) @(negedge clk);
    reg_index = '{REG_LEVEL_COUNT, REG_BITS_ZERO, REG_BITS_ONE, REG_BITS_TWO, REG_BITS_THREE};
    reg_value = '{count_code, b0, b1, b2, b3};
    for (r = 0; r < 5; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index[r];
      cfg_data  <= reg_value[r];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Draws fresh_pct percent fresh; else revisits an earlier address, exactly or with all
  // below the interior path scrambled, so that walks reach the leaves of nodes that exist.
  function automatic logic [ADDR_W-1:0] pick_address(input int fresh_pct, input int keep_bits);
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] low_mask;
    int r;
    r = $urandom_range(99);
    if (recent_addrs.size() == 0 || r < fresh_pct) begin
      addr = $urandom;
    end else begin
      addr = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
      if (r < fresh_pct + (100 - fresh_pct) / 2) begin
        low_mask = 32'hFFFF_FFFF >> keep_bits;
        addr = (addr & ~low_mask) | ($urandom & low_mask);
      end
    end
    return addr;
  endfunction

  task automatic run_phase(input logic [CFG_DATA_W-1:0] count_code, b0, b1, b2, b3,
                           input int n_items, input int fresh_pct, input idle_mode_e mode);
    int widths [4];
    int keep_bits;
    int lvl;
    int k;
    logic op;
    logic [ADDR_W-1:0] addr;
    logic [FRAME_W-1:0] frame;
    program_levels(count_code, b0, b1, b2, b3);
    set_idle_mode(mode);
    widths = '{b0, b1, b2, b3};
    keep_bits = 0;
    for (lvl = 0; lvl < 3 && lvl + 1 < count_code; lvl++) begin
      keep_bits += widths[lvl];
    end
    if (keep_bits > 31) begin
      keep_bits = 31;
    end
    for (k = 0; k < n_items; k++) begin
      op   = ($urandom_range(99) < 45) ? OP_INSERT : OP_LOOKUP;
      addr = pick_address(fresh_pct, keep_bits);
      case ($urandom_range(19))
        0:       frame = '0;
        1:       frame = '1;
        default: frame = $urandom;
      endcase
      recent_addrs.push_back(addr);
      if (recent_addrs.size() > HISTORY_DEPTH) begin
        void'(recent_addrs.pop_front());
      end
      send_request(op, addr, frame);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_LEVEL_COUNT;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setup: one level of eight bits, so the root holds the leaves.
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
    send_request(OP_INSERT, 32'h0000_0000, 32'h0);
    send_request(OP_LOOKUP, 32'h00FF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_INSERT, 32'hFFFF_0000, 32'h1234_5678);
    send_request(OP_LOOKUP, 32'h8000_0000, 32'h0);

    // Two one-bit levels: leaf fields left in the root must not read as child pointers.
    program_levels(4'd2, 4'd1, 4'd1, 4'd8, 4'd8);
    send_request(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    send_request(OP_LOOKUP, 32'hC000_0000, 32'h0);
    send_request(OP_LOOKUP, 32'h4000_0000, 32'h0);
    send_request(OP_LOOKUP, 32'hBFFF_FFFF, 32'h0);

    // Deepest legal split, leaving a single offset bit.
    program_levels(4'd4, 4'd8, 4'd8, 4'd8, 4'd7);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
    send_request(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0);
    send_request(OP_LOOKUP, 32'h0000_0002, 32'h0);

    // Rejected setups, then one where the unused levels carry zero bits.
    program_levels(4'd4, 4'd8, 4'd8, 4'd8, 4'd8);
    send_request(OP_INSERT, 32'h1357_9BDF, 32'h2468_ACE0);
    program_levels(4'd8, 4'd8, 4'd8, 4'd8, 4'd8);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    program_levels(4'd5, 4'd1, 4'd1, 4'd1, 4'd1);
    send_request(OP_INSERT, 32'h0000_0000, 32'h1);
    program_levels(4'd2, 4'd0, 4'd8, 4'd8, 4'd8);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h2);
    program_levels(4'd3, 4'd8, 4'd9, 4'd8, 4'd8);
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
    program_levels(4'd1, 4'd15, 4'd8, 4'd8, 4'd8);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h3);
    program_levels(4'd1, 4'd8, 4'd0, 4'd0, 4'd0);
    send_request(OP_INSERT, 32'h1234_5678, 32'h1);

    run_phase(4'd1, 4'd8, 4'd8, 4'd8, 4'd8, 120, 40, IDLE_NONE);
    run_phase(4'd1, 4'd1, 4'd8, 4'd8, 4'd8, 100, 40, IDLE_SENDER);
    run_phase(4'd2, 4'd8, 4'd8, 4'd8, 4'd8, 130, 10, IDLE_RECEIVER);
    run_phase(4'd2, 4'd4, 4'd3, 4'd8, 4'd8, 120, 15, IDLE_BOTH);
    run_phase(4'd3, 4'd8, 4'd8, 4'd8, 4'd8, 150, 8, IDLE_NONE);
    run_phase(4'd3, 4'd2, 4'd1, 4'd5, 4'd8, 120, 15, IDLE_SENDER);
    run_phase(4'd4, 4'd8, 4'd8, 4'd8, 4'd7, 200, 6, IDLE_RECEIVER);
    run_phase(4'd4, 4'd1, 4'd1, 4'd1, 4'd1, 150, 30, IDLE_BOTH);
    run_phase(4'd4, 4'd3, 4'd5, 4'd7, 4'd2, 120, 10, IDLE_NONE);
    run_phase(4'd1, 4'd8, 4'd0, 4'd0, 4'd0, 60, 40, IDLE_SENDER);
    run_phase(4'd3, 4'd8, 4'd8, 4'd8, 4'd15, 60, 10, IDLE_RECEIVER);
    run_phase(4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 20, 40, IDLE_BOTH);
    run_phase(4'd4, 4'd8, 4'd8, 4'd8, 4'd8, 20, 40, IDLE_NONE);
    // Many fresh inserts on the deepest split run the node pool dry.
    run_phase(4'd4, 4'd8, 4'd8, 4'd8, 4'd7, 200, 60, IDLE_BOTH);

    in_tvalid <= 1'b0;
    while (pending_walks != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mlptw_pkg.sv
rtl/mlptw_index.sv
rtl/multilevel_page_table_walker_top.sv
tb/page_walk_checker.sv
tb/multilevel_page_table_walker_top_tb.sv
